[rtl/core/infix_expression_evaluator_top_assert.svh]
// Assertion macros shared by the evaluator RTL.
// Uses the clk and rst_n names of the including module.
`ifndef INFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH

// same-cycle implication
`define IEE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IEE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/iee_pkg.sv]
// Shared types and constants of the infix expression evaluator.
// No dependencies.
package iee_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DEPTH   = 16;
    localparam int OUT_WIDTH   = 32;
    localparam int SP_WIDTH    = $clog2(MAX_DEPTH + 1);
    localparam int ADDR_WIDTH  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_TIMES  = 8'h2A;
    localparam logic [7:0] CH_DIVIDE = 8'h2F;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
    localparam logic [1:0] ERR_DEPTH    = 2'd2;
    localparam logic [1:0] ERR_UNCLOSED = 2'd3;

    typedef enum logic [1:0] {
        OP_PLUS   = 2'd0,
        OP_MINUS  = 2'd1,
        OP_TIMES  = 2'd2,
        OP_DIVIDE = 2'd3
    } op_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] sum;
        logic [VALUE_WIDTH-1:0] term;
        op_t                    op;
    } stack_entry_t;

    localparam int ENTRY_WIDTH = $bits(stack_entry_t);

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[rtl/core/iee_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/iee_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on iee_pkg and the assertion macro header.
`include "infix_expression_evaluator_top_assert.svh"

module iee_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [iee_pkg::VALUE_WIDTH-1:0] dividend,
    input  logic [iee_pkg::VALUE_WIDTH-1:0] divisor,
    output iee_pkg::div_stat_t              stat,
    output logic [iee_pkg::VALUE_WIDTH-1:0] quotient
);

    import iee_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   neg_reg, neg_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] dvs_reg, dvs_next;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic                   ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        ge    = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;

        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[VALUE_WIDTH-1] ? (~dividend + 1'b1) : dividend;
            dvs_next  = divisor[VALUE_WIDTH-1] ? (~divisor + 1'b1) : divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
            quo_next = {quo_reg[VALUE_WIDTH-2:0], ge};
            if (cnt_reg == CNT_WIDTH'(VALUE_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                cnt_next  = '0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    `IEE_ASSERT_NOW(a_start_idle, start, !busy_reg, "divider started while busy")
    `IEE_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "divider done held over two cycles")
    `IEE_ASSERT_NOW(a_cnt_idle, !busy_reg, cnt_reg == '0, "step count nonzero while idle")

endmodule

[rtl/core/infix_expression_evaluator_top.sv]
// Infix expression evaluator: one ASCII character per input item, value on last.
// Depends on iee_pkg, iee_ram, iee_div and the assertion macro header.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------
//  input   | in_valid / in_ready | symbol[7:0], last
//  output  | out_valid/out_ready | value[31:0] signed, error[1:0]
//
// Digits, '(' and others stay in S_IDLE; an operator runs S_APPLY and S_POST, a ')'
// closing a level also S_POP. A '/' with a nonzero divisor waits in S_DIVW (shared
// divider, a bit a cycle). The last item closes open levels and ends from S_FIN (one
// S_APPLY fewer after an operator). in_ready is low while an item is in work; a
// finished result waits in the output register, and the next final result stalls
// until it is taken. Reset is asynchronous, active low; the stack RAM needs no clearing.
`include "infix_expression_evaluator_top_assert.svh"

module infix_expression_evaluator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    symbol,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [iee_pkg::OUT_WIDTH-1:0] value,
    output logic [1:0]                    error
);

    import iee_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_APPLY = 6'b000010,
        S_DIVW  = 6'b000100,
        S_POST  = 6'b001000,
        S_POP   = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        C_OPER  = 2'd0,
        C_CLOSE = 2'd1,
        C_FINAL = 2'd2
    } cont_t;

    state_t                 state_reg, state_next;
    cont_t                  cont_reg, cont_next;
    logic [SP_WIDTH-1:0]    sp_reg, sp_next;
    logic [VALUE_WIDTH-1:0] sum_reg, sum_next;
    logic [VALUE_WIDTH-1:0] term_reg, term_next;
    logic [VALUE_WIDTH-1:0] num_reg, num_next;
    op_t                    op_reg, op_next;
    op_t                    sym_op_reg, sym_op_next;
    logic                   in_num_reg, in_num_next;
    logic [1:0]             err_reg, err_next;
    logic                   last_reg, last_next;
    logic                   skip_reg, skip_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_WIDTH-1:0]   value_reg, value_next;
    logic [1:0]             error_out_reg, error_out_next;

    logic                   is_digit, is_op;
    op_t                    dec_op;
    logic [VALUE_WIDTH-1:0] digit_val, num_base, flushed, applied;
    logic [2*VALUE_WIDTH-1:0] product;
    logic [SP_WIDTH-1:0]    sp_dec;
    logic                   push_we, pop_re, div_start;
    stack_entry_t           push_entry, pop_entry;
    logic [ENTRY_WIDTH-1:0] pop_data;
    div_stat_t              div_stat;
    logic [VALUE_WIDTH-1:0] div_q;

    iee_ram #(
        .WIDTH(ENTRY_WIDTH),
        .DEPTH(MAX_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (push_we),
        .waddr (sp_reg[ADDR_WIDTH-1:0]),
        .wdata (push_entry),
        .re    (pop_re),
        .raddr (sp_dec[ADDR_WIDTH-1:0]),
        .rdata (pop_data)
    );

    iee_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (term_reg),
        .divisor  (num_reg),
        .stat     (div_stat),
        .quotient (div_q)
    );

    always_comb
    begin
        is_digit  = (symbol >= CH_ZERO) && (symbol <= CH_NINE);
        is_op     = (symbol == CH_PLUS) || (symbol == CH_MINUS) ||
                    (symbol == CH_TIMES) || (symbol == CH_DIVIDE);
        case (symbol)
            CH_PLUS:  dec_op = OP_PLUS;
            CH_MINUS: dec_op = OP_MINUS;
            CH_TIMES: dec_op = OP_TIMES;
            default:  dec_op = OP_DIVIDE;
        endcase
        digit_val = VALUE_WIDTH'(symbol[3:0]);
        num_base  = in_num_reg ? num_reg : '0;
        product   = term_reg * num_reg;
        case (op_reg)
            OP_PLUS:  applied = term_reg + num_reg;
            OP_MINUS: applied = term_reg - num_reg;
            OP_TIMES: applied = product[VALUE_WIDTH-1:0];
            default:  applied = '0;
        endcase
        flushed    = sum_reg + term_reg;
        sp_dec     = sp_reg - SP_WIDTH'(1);
        push_entry = '{sum: sum_reg, term: term_reg, op: op_reg};
        pop_entry  = stack_entry_t'(pop_data);
    end

    always_comb
    begin
        state_next     = state_reg;
        cont_next      = cont_reg;
        sp_next        = sp_reg;
        sum_next       = sum_reg;
        term_next      = term_reg;
        num_next       = num_reg;
        op_next        = op_reg;
        sym_op_next    = sym_op_reg;
        in_num_next    = in_num_reg;
        err_next       = err_reg;
        last_next      = last_reg;
        skip_next      = skip_reg;
        out_valid_next = out_valid_reg && !out_ready;
        value_next     = value_reg;
        error_out_next = error_out_reg;
        push_we        = 1'b0;
        pop_re         = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    last_next   = last;
                    skip_next   = is_op && last;
                    in_num_next = 1'b0;
                    state_next  = last ? S_FIN : S_IDLE;
                    if (is_digit)
                    begin
                        num_next    = (num_base << 3) + (num_base << 1) + digit_val;
                        in_num_next = 1'b1;
                    end
                    else if (is_op)
                    begin
                        sym_op_next = dec_op;
                        cont_next   = C_OPER;
                        state_next  = S_APPLY;
                    end
                    else if (symbol == CH_OPEN)
                    begin
                        if (sp_reg >= SP_WIDTH'(MAX_DEPTH))
                        begin
                            if (err_reg == ERR_NONE)
                            begin
                                err_next = ERR_DEPTH;
                            end
                        end
                        else
                        begin
                            push_we   = 1'b1;
                            sp_next   = sp_reg + 1'b1;
                            sum_next  = '0;
                            term_next = '0;
                            op_next   = OP_PLUS;
                            num_next  = '0;
                        end
                    end
                    else if (symbol == CH_CLOSE && sp_reg != '0)
                    begin
                        cont_next  = C_CLOSE;
                        state_next = S_APPLY;
                    end
                end
            end

            S_APPLY:
            begin
                state_next = S_POST;
                if (op_reg == OP_DIVIDE)
                begin
                    if (num_reg == '0)
                    begin
                        term_next = '0;
                        if (err_reg == ERR_NONE)
                        begin
                            err_next = ERR_DIV_ZERO;
                        end
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIVW;
                    end
                end
                else
                begin
                    term_next = applied;
                end
            end

            S_DIVW:
            begin
                if (div_stat.done)
                begin
                    term_next  = div_q;
                    state_next = S_POST;
                end
            end

            S_POST:
            begin
                case (cont_reg)
                    C_OPER:
                    begin
                        if (sym_op_reg == OP_PLUS || sym_op_reg == OP_MINUS)
                        begin
                            sum_next  = flushed;
                            term_next = '0;
                        end
                        op_next     = sym_op_reg;
                        num_next    = '0;
                        in_num_next = 1'b0;
                        state_next  = last_reg ? S_FIN : S_IDLE;
                    end
                    C_CLOSE:
                    begin
                        num_next   = flushed;
                        pop_re     = 1'b1;
                        sp_next    = sp_dec;
                        state_next = S_POP;
                    end
                    C_FINAL:
                    begin
                        // result slot must be free at this edge
                        if (!out_valid_reg || out_ready)
                        begin
                            out_valid_next = 1'b1;
                            value_next     = flushed[OUT_WIDTH-1:0];
                            error_out_next = err_reg;
                            sp_next        = '0;
                            sum_next       = '0;
                            term_next      = '0;
                            num_next       = '0;
                            op_next        = OP_PLUS;
                            in_num_next    = 1'b0;
                            err_next       = ERR_NONE;
                            last_next      = 1'b0;
                            skip_next      = 1'b0;
                            state_next     = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_POP:
            begin
                sum_next    = pop_entry.sum;
                term_next   = pop_entry.term;
                op_next     = pop_entry.op;
                in_num_next = 1'b0;
                state_next  = last_reg ? S_FIN : S_IDLE;
            end

            S_FIN:
            begin
                // close open levels innermost first, then the final apply
                if (sp_reg != '0)
                begin
                    cont_next = C_CLOSE;
                    if (err_reg == ERR_NONE)
                    begin
                        err_next = ERR_UNCLOSED;
                    end
                end
                else
                begin
                    cont_next = C_FINAL;
                end
                skip_next  = 1'b0;
                state_next = skip_reg ? S_POST : S_APPLY;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cont_reg      <= C_OPER;
            sp_reg        <= '0;
            sum_reg       <= '0;
            term_reg      <= '0;
            num_reg       <= '0;
            op_reg        <= OP_PLUS;
            sym_op_reg    <= OP_PLUS;
            in_num_reg    <= 1'b0;
            err_reg       <= ERR_NONE;
            last_reg      <= 1'b0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cont_reg      <= cont_next;
            sp_reg        <= sp_next;
            sum_reg       <= sum_next;
            term_reg      <= term_next;
            num_reg       <= num_next;
            op_reg        <= op_next;
            sym_op_reg    <= sym_op_next;
            in_num_reg    <= in_num_next;
            err_reg       <= err_next;
            last_reg      <= last_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        error_out_reg <= error_out_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign error     = error_out_reg;

    `IEE_ASSERT_NOW(a_sp_bound, 1'b1, sp_reg <= SP_WIDTH'(MAX_DEPTH), "stack pointer past depth")
    `IEE_ASSERT_NOW(a_divw_busy, state_reg == S_DIVW, div_stat.busy || div_stat.done,
        "waiting on an idle divider")
    `IEE_ASSERT_NEXT(a_first_error,
        err_reg != ERR_NONE && !(state_reg == S_POST && cont_reg == C_FINAL),
        err_reg == $past(err_reg), "first error overwritten")
    `IEE_ASSERT_NOW(a_pop_nonempty, state_reg == S_POST && cont_reg == C_CLOSE,
        sp_reg != '0, "pop from empty stack")

endmodule
